@@ rtl/core/stack_ended_queue_top_macros.svh @@
// ----------------------------------------------------------------------------
// Stack-ended queue assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_ENDED_QUEUE_TOP_MACROS_SVH
`define STACK_ENDED_QUEUE_TOP_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define SEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define SEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/seq_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack-ended queue package
// Field widths, action and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package seq_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF      = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Action codes
    localparam action_t ACT_ENQUEUE = 3'd0;
    localparam action_t ACT_PUSH    = 3'd1;
    localparam action_t ACT_POP     = 3'd2;
    localparam action_t ACT_ROTATE  = 3'd3;
    localparam action_t ACT_PEEK    = 3'd4;
    localparam action_t ACT_CLEAR   = 3'd5;

    // Status codes
    localparam status_t STS_OK        = 2'd0;
    localparam status_t STS_UNDERFLOW = 2'd1;
    localparam status_t STS_OVERFLOW  = 2'd2;

endpackage

@@ rtl/core/seq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/stack_ended_queue_top.sv @@
// An accepted transfer is captured and its front entry read from the entry RAM; in
// ST_EXEC the item then runs its read-modify-write and its result is registered in
// the result slot. No new item is accepted until the current one has executed.
// A result waiting on m_axis_tready holds the next item in execute and stalls
// the transfer after it.
// Reset clears head, count, state and the output valid; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Stack-ended queue top level
// Bounded steque on a RAM ring with head index and entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_ended_queue_top #(
    parameter int DEPTH      = seq_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = seq_pkg::ITEM_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int RES_W     = seq_pkg::VALUE_W + seq_pkg::STATUS_W + CNT_W + 1,
    localparam int OUT_W     = ((RES_W + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [seq_pkg::VALUE_W-1:0]  s_axis_tdata,  // [31:0] item_value
    input  logic [seq_pkg::ACTION_W-1:0] s_axis_tuser,  // [2:0] action
    // Result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // front_value, status, entry_count (CNT_W), is_empty, zero fill
    output logic [OUT_W-1:0]             m_axis_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = CNT_W + 1;
    localparam int EXT_W = (ITEM_WIDTH > seq_pkg::VALUE_W) ? ITEM_WIDTH : seq_pkg::VALUE_W;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

    // State codes
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    seq_pkg::action_t             action_reg;
    logic [seq_pkg::VALUE_W-1:0]  item_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [seq_pkg::VALUE_W-1:0]  out_front_reg, out_front_next;
    seq_pkg::status_t             out_status_reg, out_status_next;
    logic [CNT_W-1:0]             out_count_reg;
    logic                         out_empty_reg;

    logic                         in_xfer;
    logic                         fire;
    logic                         is_full;
    logic                         is_zero;
    logic [SUM_W-1:0]             tail_sum;
    logic [IDX_W-1:0]             tail_idx;
    logic [IDX_W-1:0]             head_inc;
    logic [IDX_W-1:0]             head_dec;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ITEM_WIDTH-1:0]        ram_wdata;
    logic [ITEM_WIDTH-1:0]        ram_rdata;
    logic [EXT_W-1:0]             item_ext;
    logic [EXT_W-1:0]             rdata_ext;

    // Entry storage
    seq_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (in_xfer),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign fire          = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    // Ring index arithmetic
    assign is_full  = (count_reg == CNT_FULL);
    assign is_zero  = (count_reg == '0);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_DEPTH) ? IDX_W'(tail_sum - SUM_DEPTH)
                                              : IDX_W'(tail_sum);
    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;

    // Width adjust between port values and stored entries
    assign item_ext  = EXT_W'(item_reg);
    assign rdata_ext = EXT_W'(ram_rdata);

    // Execute one action against the front entry read when the item was accepted
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_idx;
        ram_wdata       = item_ext[ITEM_WIDTH-1:0];
        out_front_next  = '0;
        out_status_next = seq_pkg::STS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                    unique case (action_reg)
                        seq_pkg::ACT_ENQUEUE:
                        begin
                            if (is_full)
                            begin
                                out_status_next = seq_pkg::STS_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        seq_pkg::ACT_PUSH:
                        begin
                            if (is_full)
                            begin
                                out_status_next = seq_pkg::STS_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        seq_pkg::ACT_POP:
                        begin
                            if (is_zero)
                            begin
                                out_status_next = seq_pkg::STS_UNDERFLOW;
                            end
                            else
                            begin
                                out_front_next = rdata_ext[seq_pkg::VALUE_W-1:0];
                                head_next      = head_inc;
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        seq_pkg::ACT_ROTATE:
                        begin
                            // Copy the front entry to the back slot
                            if (!is_zero)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata;
                                head_next = head_inc;
                            end
                        end
                        seq_pkg::ACT_PEEK:
                        begin
                            if (is_zero)
                            begin
                                out_status_next = seq_pkg::STS_UNDERFLOW;
                            end
                            else
                            begin
                                out_front_next = rdata_ext[seq_pkg::VALUE_W-1:0];
                            end
                        end
                        seq_pkg::ACT_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // Unused codes leave the queue as is
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        priority if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the accepted transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg <= s_axis_tuser;
            item_reg   <= s_axis_tdata;
        end
    end

    // Load the result slot
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_front_reg  <= out_front_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_empty_reg, out_count_reg, out_status_reg, out_front_reg});

    // Assertions
`include "stack_ended_queue_top_macros.svh"

    `SEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_FULL, "entry count above depth")
    `SEQ_ASSERT_NEXT(a_accept_exec, in_xfer, state_reg == ST_EXEC, "accepted item not executing")
    `SEQ_ASSERT_NEXT(a_idle_hold, state_reg == ST_IDLE,
                     $stable(count_reg) && $stable(head_reg), "pointers moved while idle")
    `SEQ_ASSERT_NEXT(a_fire_result, fire,
                     m_axis_tvalid && (out_count_reg == $past(count_next)), "result slot not loaded")

endmodule
